[sv/hba_pkg.sv]
// Shared types and constants for the histogram bin accumulator.
`timescale 1ns / 1ps
`default_nettype none

package hba_pkg;

	// default number of bucket counters
	localparam int NUM_BINS_DEF = 1024;

	// widths fixed by the item and register formats
	localparam int KEY_W      = 64;
	localparam int AMOUNT_W   = 32;
	localparam int RIDX_W     = 10;
	localparam int BUCKET_W   = 10;
	localparam int COUNT_W    = 64;
	localparam int BIU_W      = 11;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 1;
	// widest bucket index over the parameter range (65536 buckets)
	localparam int IDX_MAX_W  = 16;
	// compare width for buckets_in_use against the bucket limit
	localparam int CFG_CMP_W  = 17;
	// width of the division step counter, one quotient bit per step
	localparam int DIV_STEP_W = 6;
	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// item kinds
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRANULARITY    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKETS_IN_USE = 1'b1;

	// resolved item handed from front to back
	typedef struct packed {
		logic                  op;
		logic [IDX_MAX_W-1:0]  idx;
		logic                  clamped;
		logic [AMOUNT_W-1:0]   amount;
	} q_entry_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_CLAMP,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_UPDATE
	} back_state_t;

endpackage

`default_nettype wire

[sv/hba_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module hba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/hba_front.sv]
// Front end: accepts items, finds an add's bucket by serial division, clamps it.
`timescale 1ns / 1ps
`default_nettype none

module hba_front #(
	parameter int NUM_BINS = hba_pkg::NUM_BINS_DEF,
	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1,
	localparam int CNT_W = $clog2(NUM_BINS + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input item
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         in_op,
	input  wire logic [hba_pkg::KEY_W-1:0]    in_key,
	input  wire logic [hba_pkg::AMOUNT_W-1:0] in_amount,
	input  wire logic [hba_pkg::RIDX_W-1:0]   in_read_index,
	// configuration
	input  wire logic [hba_pkg::KEY_W-1:0]    granularity,
	input  wire logic [CNT_W-1:0]             active_n,
	input  wire logic                         clearing,
	// queue side
	output logic                              push,
	output hba_pkg::q_entry_t                 push_entry,
	input  wire logic                         full
);

	localparam int KW = hba_pkg::KEY_W;
	localparam logic [hba_pkg::DIV_STEP_W-1:0] LAST_STEP = hba_pkg::DIV_STEP_W'(KW - 1);

	hba_pkg::front_state_t state_q, state_d;

	logic                            op_q;
	logic [hba_pkg::AMOUNT_W-1:0]    amount_q;
	logic [KW-1:0]                   g_q;
	logic [KW-1:0]                   rem_q;
	logic [KW-1:0]                   quo_q;    // key or read index going in, quotient coming out
	logic [hba_pkg::DIV_STEP_W-1:0]  step_q;
	logic [hba_pkg::IDX_MAX_W-1:0]   idx_q;
	logic                            clamped_q;

	logic           accept;
	logic [KW:0]    shifted;
	logic [KW+1:0]  diff;
	logic           take;
	logic           over;

	assign in_ready = (state_q == hba_pkg::F_IDLE) && !clearing;
	assign accept   = in_valid && in_ready;

	// restoring division step
	assign shifted = {rem_q, quo_q[KW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, g_q};
	assign take    = !diff[KW+1];

	assign over = (quo_q >= KW'(active_n));

	assign push_entry.op      = op_q;
	assign push_entry.idx     = idx_q;
	assign push_entry.clamped = clamped_q;
	assign push_entry.amount  = amount_q;

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		case (state_q)
			hba_pkg::F_IDLE: begin
				if (accept) begin
					state_d = (in_op == hba_pkg::OP_ADD) ? hba_pkg::F_DIV : hba_pkg::F_CLAMP;
				end
			end
			hba_pkg::F_DIV: begin
				if (step_q == LAST_STEP) begin
					state_d = hba_pkg::F_CLAMP;
				end
			end
			hba_pkg::F_CLAMP: begin
				state_d = hba_pkg::F_PUSH;
			end
			hba_pkg::F_PUSH: begin
				if (!full) begin
					push    = 1'b1;
					state_d = hba_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = hba_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hba_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			hba_pkg::F_IDLE: begin
				if (accept) begin
					op_q     <= in_op;
					amount_q <= in_amount;
					rem_q    <= '0;
					step_q   <= '0;
					g_q      <= (granularity == '0) ? KW'(1) : granularity;
					quo_q    <= (in_op == hba_pkg::OP_ADD) ? in_key : KW'(in_read_index);
				end
			end
			hba_pkg::F_DIV: begin
				rem_q  <= take ? diff[KW-1:0] : shifted[KW-1:0];
				quo_q  <= {quo_q[KW-2:0], take};
				step_q <= step_q + 1'b1;
			end
			hba_pkg::F_CLAMP: begin
				// past the buckets in use: fold into the last one
				if (over) begin
					idx_q     <= hba_pkg::IDX_MAX_W'(active_n - CNT_W'(1));
					clamped_q <= 1'b1;
				end else begin
					idx_q     <= hba_pkg::IDX_MAX_W'(quo_q[IDX_W-1:0]);
					clamped_q <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/hba_fifo.sv]
// Short queue of resolved items between front and back.
`timescale 1ns / 1ps
`default_nettype none

module hba_fifo #(
	parameter int DEPTH = hba_pkg::QUEUE_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hba_pkg::q_entry_t din,
	output logic                   full,
	input  wire logic              pop,
	output hba_pkg::q_entry_t      dout,
	output logic                   empty
);

	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	hba_pkg::q_entry_t slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/hba_back.sv]
// Back end: clears the counters, then reads each item's counter and writes adds back.
`timescale 1ns / 1ps
`default_nettype none

module hba_back #(
	parameter int NUM_BINS = hba_pkg::NUM_BINS_DEF,
	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// queue side
	input  wire logic                         empty,
	input  wire hba_pkg::q_entry_t            head,
	output logic                              pop,
	output logic                              clearing,
	// result
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [hba_pkg::BUCKET_W-1:0]      out_bucket,
	output logic [hba_pkg::COUNT_W-1:0]       out_count,
	output logic                              out_clamped
);

	localparam int CW = hba_pkg::COUNT_W;
	localparam int AW = hba_pkg::AMOUNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

	hba_pkg::back_state_t state_q, state_d;

	logic [IDX_W-1:0]   clr_q;
	hba_pkg::q_entry_t  cur_q;
	logic               out_valid_q;

	logic               ram_we, ram_re;
	logic [IDX_W-1:0]   ram_waddr, ram_raddr;
	logic [CW-1:0]      ram_wdata, ram_rdata;
	logic [CW-1:0]      sum;
	logic               load_out;

	hba_ram #(
		.WIDTH (CW),
		.DEPTH (NUM_BINS)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// signed amount, wraps modulo 2^64
	assign sum = ram_rdata + {{(CW - AW){cur_q.amount[AW-1]}}, cur_q.amount};

	assign clearing  = (state_q == hba_pkg::B_CLEAR);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = head.idx[IDX_W-1:0];
		pop       = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			hba_pkg::B_CLEAR: begin
				ram_we = 1'b1;
				if (clr_q == LAST_IDX) begin
					state_d = hba_pkg::B_IDLE;
				end
			end
			hba_pkg::B_IDLE: begin
				// start only when the result register will be free
				if (!empty && (!out_valid_q || out_ready)) begin
					pop     = 1'b1;
					ram_re  = 1'b1;
					state_d = hba_pkg::B_UPDATE;
				end
			end
			hba_pkg::B_UPDATE: begin
				load_out = 1'b1;
				if (cur_q.op == hba_pkg::OP_ADD) begin
					ram_we    = 1'b1;
					ram_waddr = cur_q.idx[IDX_W-1:0];
					ram_wdata = sum;
				end
				state_d = hba_pkg::B_IDLE;
			end
			default: begin
				state_d = hba_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hba_pkg::B_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == hba_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (load_out) begin
			out_bucket  <= cur_q.idx[hba_pkg::BUCKET_W-1:0];
			out_count   <= (cur_q.op == hba_pkg::OP_ADD) ? sum : ram_rdata;
			out_clamped <= cur_q.clamped;
		end
	end

endmodule

`default_nettype wire

[sv/histogram_bin_accumulator.sv]
// Top level of the histogram bin accumulator: config registers, front, queue, back.
//
// Usage:
//   s_* carries items in: op in s_tuser (0 add, 1 read), key/amount/read_index in s_tdata.
//   m_* carries one result per item: bucket and count in m_tdata, clamped flag in m_tuser.
//   cfg_we/cfg_index/cfg_wdata write granularity (index 0) or buckets_in_use (index 1);
//   write only while no item is in flight.
// Item flow:
//   An add item passes the accept, divide, clamp and push states in the front; the
//   serial divider makes one quotient bit per cycle. A read item skips the divider.
//   The front takes no new item until it has pushed the current one to the queue.
//   The back reads the counter from RAM, then updates and writes it (adds only) and
//   loads the result into the output register.
// Reset:
//   arst_n clears control state; the back then sweeps all NUM_BINS counters to
//   zero, one per cycle, with s_tready held low.
// Stalls:
//   A result waits in the output register while m_tready is low; the two-entry
//   queue and the front keep working until the queue fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module histogram_bin_accumulator #(
	parameter int NUM_BINS = hba_pkg::NUM_BINS_DEF,
	localparam int CNT_W = $clog2(NUM_BINS + 1)
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input items
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// key[63:0], amount[95:64], read_index[105:96]
	input  wire logic [111:0]                   s_tdata,
	input  wire logic                           s_tuser,   // op
	// results
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [79:0]                         m_tdata,   // bucket[9:0], count[73:10]
	output logic                                m_tuser,   // clamped
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [hba_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hba_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CMP_W = hba_pkg::CFG_CMP_W;

	logic [hba_pkg::KEY_W-1:0] granularity_q;
	logic [hba_pkg::BIU_W-1:0] biu_q;
	logic [CMP_W-1:0]          biu_cmp;
	logic [CNT_W-1:0]          active_n;

	logic                      clearing;
	logic                      fifo_push, fifo_pop, fifo_full, fifo_empty;
	hba_pkg::q_entry_t         push_entry, head;

	logic [hba_pkg::BUCKET_W-1:0] out_bucket;
	logic [hba_pkg::COUNT_W-1:0]  out_count;

	// configuration registers; unknown indexes cannot occur with a 1-bit index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granularity_q <= hba_pkg::KEY_W'(1);
			biu_q         <= hba_pkg::BIU_W'(1024);
		end else if (cfg_we) begin
			case (cfg_index)
				hba_pkg::REG_GRANULARITY:    granularity_q <= cfg_wdata;
				hba_pkg::REG_BUCKETS_IN_USE: biu_q <= cfg_wdata[hba_pkg::BIU_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// buckets in use: zero counts as one, capped at NUM_BINS
	always_comb begin
		biu_cmp = CMP_W'(biu_q);
		if (biu_q == '0) begin
			biu_cmp = CMP_W'(1);
		end else if (biu_cmp > CMP_W'(NUM_BINS)) begin
			biu_cmp = CMP_W'(NUM_BINS);
		end
	end
	assign active_n = CNT_W'(biu_cmp);

	hba_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_op         (s_tuser),
		.in_key        (s_tdata[63:0]),
		.in_amount     (s_tdata[95:64]),
		.in_read_index (s_tdata[105:96]),
		.granularity   (granularity_q),
		.active_n      (active_n),
		.clearing      (clearing),
		.push          (fifo_push),
		.push_entry    (push_entry),
		.full          (fifo_full)
	);

	hba_fifo #(
		.DEPTH (hba_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.din    (push_entry),
		.full   (fifo_full),
		.pop    (fifo_pop),
		.dout   (head),
		.empty  (fifo_empty)
	);

	hba_back #(
		.NUM_BINS (NUM_BINS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (fifo_empty),
		.head        (head),
		.pop         (fifo_pop),
		.clearing    (clearing),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_bucket  (out_bucket),
		.out_count   (out_count),
		.out_clamped (m_tuser)
	);

	assign m_tdata = {6'b0, out_count, out_bucket};

	// no items taken while the counters are being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("item accepted during clearing pass");

	// front never pushes into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_push && fifo_full))
		else $error("queue overflow");

	// back never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_pop && fifo_empty))
		else $error("queue underflow");

endmodule

`default_nettype wire

[dv/tb_histogram_bin_accumulator.sv]
// Self-checking testbench for the histogram bin accumulator: directed edges, then random traffic.
`timescale 1ns / 1ps

module tb_histogram_bin_accumulator;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 10;
	// bound on run length, to stop a run that hangs
	localparam int CYCLE_LIMIT   = 1000000;
	// random items per idle pattern, three patterns in total
	localparam int PHASE_ITEMS   = 633;
	// idle time after the last result, before the summary
	localparam int SETTLE_CYCLES = 10;

	// one expected result item
	typedef struct packed {
		logic [hba_pkg::BUCKET_W-1:0] bucket;
		logic [hba_pkg::COUNT_W-1:0]  count;
		logic                         clamped;
	} bin_result_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           s_tvalid  = 1'b0;
	logic                           s_tready;
	logic [111:0]                   s_tdata   = '0; // key[63:0], amount[95:64], read_index[105:96]
	logic                           s_tuser   = hba_pkg::OP_ADD; // op
	logic                           m_tvalid;
	logic                           m_tready  = 1'b0;
	logic [79:0]                    m_tdata;        // bucket[9:0], count[73:10]
	logic                           m_tuser;        // clamped
	logic                           cfg_we    = 1'b0;
	logic [hba_pkg::CFG_IDX_W-1:0]  cfg_index = hba_pkg::REG_GRANULARITY;
	logic [hba_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow of the block's counters and registers
	logic [hba_pkg::COUNT_W-1:0] bin_counts [hba_pkg::NUM_BINS_DEF];
	logic [hba_pkg::KEY_W-1:0]   granularity_q;
	logic [hba_pkg::BIU_W-1:0]   buckets_q;
	// results still owed by the block, oldest first
	bin_result_t        pending_bins [$];
	bin_result_t        want;

	int snd_idle_pct;
	int rcv_idle_pct;
	int err_count;
	int items_sent;
	int reads_sent;
	int results_checked;
	int clamped_seen;
	int cfg_writes;
	int cycle_count;

	histogram_bin_accumulator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #CLK_HALF clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[histogram_bin_accumulator] ERROR");
			$finish;
		end
	end

	// effective bucket count: zero counts as one, capped at the store size
	function automatic int active_bins();
		if (buckets_q == 0)
			return 1;
		if (buckets_q > hba_pkg::NUM_BINS_DEF)
			return hba_pkg::NUM_BINS_DEF;
		return int'(buckets_q);
	endfunction

	// bin one item against the shadow state, update it, return the result
	function automatic bin_result_t predict_bin(logic op, logic [hba_pkg::KEY_W-1:0] key,
			logic [hba_pkg::AMOUNT_W-1:0] amount, logic [hba_pkg::RIDX_W-1:0] ridx);
		logic [hba_pkg::KEY_W-1:0] span;
		logic [hba_pkg::KEY_W-1:0] idx;
		logic [hba_pkg::KEY_W-1:0] n;
		bin_result_t               r;
		n = 64'(active_bins());
		span = (granularity_q == 0) ? 64'd1 : granularity_q;
		r.clamped = 1'b0;
		if (op == hba_pkg::OP_ADD)
			idx = key / span;
		else
			idx = 64'(ridx);
		// overflow bucket: anything at or past the range lands in the last one
		if (idx >= n) begin
			idx = n - 1;
			r.clamped = 1'b1;
		end
		if (op == hba_pkg::OP_ADD)
			bin_counts[idx[9:0]] += {{32{amount[hba_pkg::AMOUNT_W-1]}}, amount};
		r.bucket = idx[hba_pkg::BUCKET_W-1:0];
		r.count = bin_counts[idx[9:0]];
		return r;
	endfunction

	// present one item, hold it until taken, then record what it should produce.
	// tvalid stays high after the handshake so back-to-back items need no toggle.
	task automatic send_item(logic op, logic [hba_pkg::KEY_W-1:0] key,
			logic [hba_pkg::AMOUNT_W-1:0] amount, logic [hba_pkg::RIDX_W-1:0] ridx);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, ridx, amount, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_bins.push_back(predict_bin(op, key, amount, ridx));
		items_sent++;
		if (op == hba_pkg::OP_READ)
			reads_sent++;
	endtask

	// stop sending and let every owed result come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_bins.size() != 0)
			@(posedge clk);
	endtask

	// registers only change with nothing in flight
	task automatic write_reg(logic [hba_pkg::CFG_IDX_W-1:0] idx,
			logic [hba_pkg::CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == hba_pkg::REG_GRANULARITY)
			granularity_q = value;
		else
			buckets_q = value[hba_pkg::BIU_W-1:0];
		cfg_writes++;
		@(posedge clk);
	endtask

	// result checker: every taken result against the oldest expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (pending_bins.size() == 0) begin
				$error("unexpected result: bucket %0d count 0x%0h clamped %0b",
					m_tdata[hba_pkg::BUCKET_W-1:0],
					m_tdata[hba_pkg::BUCKET_W +: hba_pkg::COUNT_W], m_tuser);
				err_count++;
			end else begin
				want = pending_bins.pop_front();
				results_checked++;
				if (want.clamped)
					clamped_seen++;
				if (m_tdata[hba_pkg::BUCKET_W-1:0] !== want.bucket) begin
					$error("bucket: expected %0d, got %0d", want.bucket,
						m_tdata[hba_pkg::BUCKET_W-1:0]);
					err_count++;
				end
				if (m_tdata[hba_pkg::BUCKET_W +: hba_pkg::COUNT_W] !== want.count) begin
					$error("count: expected 0x%0h, got 0x%0h", want.count,
						m_tdata[hba_pkg::BUCKET_W +: hba_pkg::COUNT_W]);
					err_count++;
				end
				if (m_tuser !== want.clamped) begin
					$error("clamped: expected %0b, got %0b", want.clamped, m_tuser);
					err_count++;
				end
			end
		end
	end

	// store starts cleared: first and last bucket read back zero
	task automatic test_reset_state();
		send_item(hba_pkg::OP_READ, '0, '0, 10'd0);
		send_item(hba_pkg::OP_READ, '1, '1, 10'd1023);
	endtask

	// default binning: span 1, all 1024 buckets; keys at and past the top
	task automatic test_bin_edges();
		send_item(hba_pkg::OP_ADD, 64'd0, 32'd1, '0);
		send_item(hba_pkg::OP_ADD, 64'd1023, 32'd2, '1);
		send_item(hba_pkg::OP_ADD, 64'd1024, 32'd3, '0);
		send_item(hba_pkg::OP_ADD, '1, 32'd4, '0);
	endtask

	// signed amounts: extremes, negative from zero, wrap through 2^64
	task automatic test_amount_wrap();
		send_item(hba_pkg::OP_ADD, 64'd5, 32'h7FFF_FFFF, '0);
		send_item(hba_pkg::OP_ADD, 64'd5, 32'h8000_0000, '0);
		send_item(hba_pkg::OP_ADD, 64'd5, 32'd1, '0);
		send_item(hba_pkg::OP_ADD, 64'd6, 32'hFFFF_FFFF, '0);
	endtask

	// span of zero acts as one; full-width span; exact top edge of a mid span
	task automatic test_granularity();
		write_reg(hba_pkg::REG_GRANULARITY, 64'd0);
		send_item(hba_pkg::OP_ADD, 64'd9, 32'd1, '0);
		write_reg(hba_pkg::REG_GRANULARITY, '1);
		send_item(hba_pkg::OP_ADD, '1, 32'd1, '0);
		send_item(hba_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFE, 32'd1, '0);
		write_reg(hba_pkg::REG_GRANULARITY, 64'd1000);
		send_item(hba_pkg::OP_ADD, 64'd1023999, 32'd1, '0);
		send_item(hba_pkg::OP_ADD, 64'd1024000, 32'd1, '0);
	endtask

	// zero and oversize bucket counts, clamped reads, counters kept while hidden
	task automatic test_buckets_in_use();
		write_reg(hba_pkg::REG_GRANULARITY, 64'd1);
		write_reg(hba_pkg::REG_BUCKETS_IN_USE, 64'd0);
		send_item(hba_pkg::OP_ADD, 64'd3, 32'd5, '0);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd0);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd1023);
		write_reg(hba_pkg::REG_BUCKETS_IN_USE, 64'd2047);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd1023);
		send_item(hba_pkg::OP_ADD, 64'd1023, 32'd1, '0);
		write_reg(hba_pkg::REG_BUCKETS_IN_USE, 64'd4);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd9);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd3);
		write_reg(hba_pkg::REG_BUCKETS_IN_USE, 64'd1024);
		send_item(hba_pkg::OP_READ, '0, '0, 10'd9);
	endtask

	// new register setting, biased toward the edges
	task automatic pick_settings();
		logic [hba_pkg::KEY_W-1:0]      span;
		logic [hba_pkg::BIU_W-1:0]      nb;
		logic [hba_pkg::CFG_DATA_W-1:0] word;
		case ($urandom_range(7))
			0: span = 64'd0;
			1: span = 64'd1;
			2, 3: span = 64'($urandom_range(2, 16));
			4: span = 64'($urandom_range(17, 100000));
			5: span = '1;
			6: span = 64'd1 << $urandom_range(0, 63);
			default: span = {$urandom, $urandom};
		endcase
		case ($urandom_range(6))
			0: nb = 11'd0;
			1: nb = 11'd1;
			2: nb = 11'($urandom_range(2, 64));
			3: nb = 11'($urandom_range(65, 1023));
			4: nb = 11'd1024;
			5: nb = 11'($urandom_range(1025, 2047));
			default: nb = 11'd2047;
		endcase
		// bits above the register width are ignored; sometimes fill them
		word = {$urandom, $urandom};
		if ($urandom_range(1))
			word = '0;
		word[hba_pkg::BIU_W-1:0] = nb;
		write_reg(hba_pkg::REG_GRANULARITY, span);
		write_reg(hba_pkg::REG_BUCKETS_IN_USE, word);
	endtask

	// three quarters adds, keys aimed at live buckets, small or wild; a quarter reads
	task automatic send_random_item();
		logic [hba_pkg::KEY_W-1:0]    span;
		logic [hba_pkg::KEY_W-1:0]    key;
		logic [hba_pkg::AMOUNT_W-1:0] amount;
		span = (granularity_q == 0) ? 64'd1 : granularity_q;
		if ($urandom_range(99) < 25) begin
			send_item(hba_pkg::OP_READ, {$urandom, $urandom}, $urandom,
				hba_pkg::RIDX_W'($urandom));
			return;
		end
		case ($urandom_range(2))
			0: key = span * 64'($urandom_range(0, active_bins() + 2)) + ({$urandom, $urandom} % span);
			1: key = 64'($urandom_range(0, 4095));
			default: key = {$urandom, $urandom};
		endcase
		case ($urandom_range(3))
			0, 1: amount = 32'($urandom_range(0, 40)) - 32'd20;
			2: amount = $urandom;
			default: amount = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		endcase
		send_item(hba_pkg::OP_ADD, key, amount, hba_pkg::RIDX_W'($urandom));
	endtask

	// one idle pattern, three register settings
	task automatic test_random_traffic(int n_items, int snd, int rcv);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		repeat (3) begin
			pick_settings();
			repeat (n_items / 3)
				send_random_item();
		end
	endtask

	initial begin
		foreach (bin_counts[i])
			bin_counts[i] = '0;
		granularity_q = 64'd1;
		buckets_q = 11'd1024;
		snd_idle_pct = 18;
		rcv_idle_pct = 72;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// block clears its store after reset; items simply wait for tready

		test_reset_state();
		test_bin_edges();
		test_amount_wrap();
		test_granularity();
		test_buckets_in_use();

		test_random_traffic(PHASE_ITEMS, 18, 72);
		test_random_traffic(PHASE_ITEMS, 72, 18);
		test_random_traffic(PHASE_ITEMS, 0, 0);

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Run covered %0d items (%0d reads), %0d results checked, %0d clamped.",
			items_sent, reads_sent, results_checked, clamped_seen);
		$display("%0d register writes over three idle patterns, %0d mismatches.",
			cfg_writes, err_count);
		if (err_count == 0)
			$display("[histogram_bin_accumulator] OK");
		else
			$display("[histogram_bin_accumulator] ERROR");
		$finish;
	end

endmodule

[filelist.f]
sv/hba_pkg.sv
sv/hba_ram.sv
sv/hba_front.sv
sv/hba_fifo.sv
sv/hba_back.sv
sv/histogram_bin_accumulator.sv
dv/tb_histogram_bin_accumulator.sv
